FILE: design/sgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants for the SGR mouse and key parser
// Byte codes, command codes, the input word and the result word layouts,
// and the saturating decimal accumulate step.
// ----------------------------------------------------------------------------
package sgr_pkg;

    // Longest escape sequence body, in bytes after ESC
    localparam int MAX_SEQ   = 63;
    localparam int SEQ_CNT_W = $clog2(MAX_SEQ + 1);

    localparam int COORD_W = 16;
    localparam int BTN_W   = 3;

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    // Byte codes
    localparam logic [7:0] CHAR_ESC    = 8'h1B;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_PRESS  = 8'h4D;
    localparam logic [7:0] CHAR_REL    = 8'h6D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Button code that names no button
    localparam logic [1:0] BTN_CODE_NONE = 2'd3;

    typedef enum logic [1:0] {
        CMD_DATA   = 2'd0,
        CMD_NONE   = 2'd1,
        CMD_UPDATE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
    } item_t;

    typedef struct packed {
        logic               key_valid;
        logic [7:0]         key_code;
        logic               mouse_valid;
        logic [COORD_W-1:0] pointer_x;
        logic [COORD_W-1:0] pointer_y;
        logic [BTN_W-1:0]   buttons_now;
        logic [BTN_W-1:0]   buttons_before;
    } result_t;

    // acc * 10 + d, saturated to the coordinate width
    function automatic logic [COORD_W-1:0] sat_mac10(
        input logic [COORD_W-1:0] acc,
        input logic [3:0]         d
    );
        logic [COORD_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{COORD_W{1'b0}}, d};
        if (v > {4'b0000, COORD_MAX}) begin
            return COORD_MAX;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

FILE: design/sgr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_in_stage: input word register
// Captures one word from the input channel and holds it until the parser
// stage takes it; refills in the same cycle for full throughput.
// ----------------------------------------------------------------------------
module sgr_in_stage
    import sgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held word leaves this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    // Clear valid under reset; payload has no reset and loads on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg.cmd     <= cmd;
            item_reg.in_byte <= in_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: design/sgr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_parser: escape sequence parser and pointer state
// Walks one word per cycle, when a word is taken, through the ESC [ < b ; x ; y sequence, keeps
// the accumulated fields, and commits position and buttons when a
// well-formed report ends. Produces the result word for every word taken.
// ----------------------------------------------------------------------------
module sgr_parser
    import sgr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WANT_BRACKET,
        PH_WANT_LT,
        PH_FIELDS,
        PH_TAIL
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [SEQ_CNT_W-1:0] seq_count_reg, seq_count_next;
    logic [1:0]           field_index_reg, field_index_next;
    logic                 has_digit_reg, has_digit_next;
    logic                 malformed_reg, malformed_next;
    logic [1:0]           btn_code_reg, btn_code_next;
    logic [COORD_W-1:0]   acc_x_reg, acc_x_next;
    logic [COORD_W-1:0]   acc_y_reg, acc_y_next;
    logic [COORD_W-1:0]   held_x_reg, held_x_next;
    logic [COORD_W-1:0]   held_y_reg, held_y_next;
    logic [BTN_W-1:0]     buttons_reg, buttons_next;
    logic [BTN_W-1:0]     buttons_prev_reg, buttons_prev_next;

    cmd_t                 cmd_code;
    logic [7:0]           byte_in;
    logic [7:0]           digit_diff;
    logic [3:0]           digit;
    logic                 is_digit;
    logic [SEQ_CNT_W-1:0] count_inc;
    logic                 report_ok;
    logic                 do_finish;
    logic                 close_rel;
    logic [BTN_W-1:0]     btn_mask;

    assign cmd_code   = cmd_t'(item.cmd);
    assign byte_in    = item.in_byte;
    assign digit_diff = byte_in - CHAR_ZERO;
    assign digit      = digit_diff[3:0];
    assign is_digit   = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
    assign count_inc  = seq_count_reg + 1'b1;

    // Next state for one word
    always_comb
    begin
        phase_next        = phase_reg;
        seq_count_next    = seq_count_reg;
        field_index_next  = field_index_reg;
        has_digit_next    = has_digit_reg;
        malformed_next    = malformed_reg;
        btn_code_next     = btn_code_reg;
        acc_x_next        = acc_x_reg;
        acc_y_next        = acc_y_reg;
        held_x_next       = held_x_reg;
        held_y_next       = held_y_reg;
        buttons_next      = buttons_reg;
        buttons_prev_next = buttons_prev_reg;
        do_finish         = 1'b0;
        close_rel         = 1'b0;
        report_ok         = 1'b0;
        btn_mask          = '0;

        result                = '0;

        unique case (cmd_code)
            CMD_DATA:
            begin
                if (phase_reg == PH_IDLE) begin
                    if (byte_in == CHAR_ESC) begin
                        // Open a fresh sequence
                        phase_next = PH_WANT_BRACKET;
                    end else begin
                        result.key_valid = 1'b1;
                        result.key_code  = byte_in;
                    end
                end else begin
                    seq_count_next = count_inc;
                    // Advance the parse unless it already failed or is done
                    if (!malformed_reg && phase_reg != PH_TAIL) begin
                        if (phase_reg == PH_WANT_BRACKET) begin
                            if (byte_in == CHAR_LBRACK) begin
                                phase_next = PH_WANT_LT;
                            end else begin
                                malformed_next = 1'b1;
                            end
                        end else if (phase_reg == PH_WANT_LT) begin
                            if (byte_in == CHAR_LT) begin
                                phase_next = PH_FIELDS;
                            end else begin
                                malformed_next = 1'b1;
                            end
                        end else if (is_digit) begin
                            // Button code only matters modulo four
                            if (field_index_reg == 2'd0) begin
                                btn_code_next = {btn_code_reg[0], 1'b0} + digit[1:0];
                            end else if (field_index_reg == 2'd1) begin
                                acc_x_next = sat_mac10(acc_x_reg, digit);
                            end else begin
                                acc_y_next = sat_mac10(acc_y_reg, digit);
                            end
                            has_digit_next = 1'b1;
                        end else if (byte_in == CHAR_SEMI && field_index_reg < 2'd2
                                     && has_digit_reg) begin
                            field_index_next = field_index_reg + 1'b1;
                            has_digit_next   = 1'b0;
                        end else if (field_index_reg == 2'd2 && has_digit_reg) begin
                            phase_next = PH_TAIL;
                        end else begin
                            malformed_next = 1'b1;
                        end
                    end
                    do_finish  = (byte_in == CHAR_PRESS) || (byte_in == CHAR_REL)
                                 || (count_inc >= SEQ_CNT_W'(MAX_SEQ));
                    close_rel  = (byte_in == CHAR_REL);
                end
            end
            CMD_NONE, CMD_UPDATE:
            begin
                do_finish = (phase_reg != PH_IDLE);
            end
            default:
            begin
            end
        endcase

        // Commit a well-formed report and close the sequence
        if (do_finish) begin
            report_ok = !malformed_next && ((phase_next == PH_TAIL)
                        || (phase_next == PH_FIELDS && field_index_next == 2'd2
                            && has_digit_next));
            if (report_ok) begin
                held_x_next = acc_x_next;
                held_y_next = acc_y_next;
                if (btn_code_next != BTN_CODE_NONE) begin
                    btn_mask = BTN_W'(1) << btn_code_next;
                    if (close_rel) begin
                        buttons_next = buttons_reg & ~btn_mask;
                    end else begin
                        buttons_next = buttons_reg | btn_mask;
                    end
                end
            end
            phase_next = PH_IDLE;
        end

        // Clear the sequence scratch whenever it closes or reopens
        if (do_finish || phase_reg == PH_IDLE) begin
            seq_count_next   = '0;
            field_index_next = '0;
            has_digit_next   = 1'b0;
            malformed_next   = 1'b0;
            btn_code_next    = '0;
            acc_x_next       = '0;
            acc_y_next       = '0;
        end

        if (cmd_code == CMD_UPDATE) begin
            buttons_prev_next = buttons_next;
        end

        result.mouse_valid    = report_ok;
        result.pointer_x      = held_x_next;
        result.pointer_y      = held_y_next;
        result.buttons_now    = buttons_next;
        result.buttons_before = buttons_prev_next;
    end

    // Hold parse and pointer state; advance on each word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_IDLE;
            seq_count_reg    <= '0;
            field_index_reg  <= '0;
            has_digit_reg    <= 1'b0;
            malformed_reg    <= 1'b0;
            btn_code_reg     <= '0;
            acc_x_reg        <= '0;
            acc_y_reg        <= '0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            buttons_reg      <= '0;
            buttons_prev_reg <= '0;
        end else if (fire) begin
            phase_reg        <= phase_next;
            seq_count_reg    <= seq_count_next;
            field_index_reg  <= field_index_next;
            has_digit_reg    <= has_digit_next;
            malformed_reg    <= malformed_next;
            btn_code_reg     <= btn_code_next;
            acc_x_reg        <= acc_x_next;
            acc_y_reg        <= acc_y_next;
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
            buttons_reg      <= buttons_next;
            buttons_prev_reg <= buttons_prev_next;
        end
    end

    // A key press and a mouse report never come from the same word
    a_key_mouse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(result.key_valid && result.mouse_valid))
        else $error("key and mouse report from one word");

    // A finished report leaves the parser idle
    a_report_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.mouse_valid) |=> (phase_reg == PH_IDLE))
        else $error("parser not idle after report");

    // The byte count never reaches the limit between words
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_count_reg < SEQ_CNT_W'(MAX_SEQ))
        else $error("sequence count past limit");

    // Idle parser keeps its scratch cleared
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (seq_count_reg == '0 && !malformed_reg
                                    && acc_x_reg == '0 && acc_y_reg == '0))
        else $error("idle parser holds stale sequence state");

endmodule

FILE: design/sgr_mouse_and_key_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_mouse_and_key_parser: terminal key and SGR mouse report decoder
// Top level: input word register, parser stage and result register.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled, with no
// bubbles: each word is captured in the input register, decoded
// combinationally by the parser (a byte compare and a saturating decimal
// accumulate) and lands in the result register, which drives the outputs.
// Every word yields exactly one result word. Plain bytes are
// reported as key presses; ESC [ < b ; x ; y M/m sequences update the
// pointer position and button bits when the sequence closes on M or m,
// after MAX_SEQ bytes, or on a no-byte or begin-update command.
// Backpressure on the output stalls the whole pipe; the input stays ready
// while the result register is being drained.
// ----------------------------------------------------------------------------
module sgr_mouse_and_key_parser
    import sgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               key_valid,
    output logic [7:0]         key_code,
    output logic               mouse_valid,
    output logic [COORD_W-1:0] pointer_x,
    output logic [COORD_W-1:0] pointer_y,
    output logic [BTN_W-1:0]   buttons_now,
    output logic [BTN_W-1:0]   buttons_before
);

    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // Move a word into the result register when it is empty or draining
    assign advance = item_valid && (!out_valid_reg || out_ready);

    sgr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .in_byte    (in_byte),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sgr_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign key_valid      = result_reg.key_valid;
    assign key_code       = result_reg.key_code;
    assign mouse_valid    = result_reg.mouse_valid;
    assign pointer_x      = result_reg.pointer_x;
    assign pointer_y      = result_reg.pointer_y;
    assign buttons_now    = result_reg.buttons_now;
    assign buttons_before = result_reg.buttons_before;

    // A stalled result is never dropped
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("stalled result lost");

    // The parser only advances when the result register can take the word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while stalled");

endmodule
